[design/bitmap_slot_allocator_top_macros.svh]
// assertion macros for the allocator rtl
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
// property checked every clock outside reset
`define BSA_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define BSA_ASSERT_NXT(lbl, clk_s, rstn_s, pre, post, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) pre |=> post) else $error(msg);
`else
`define BSA_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define BSA_ASSERT_NXT(lbl, clk_s, rstn_s, pre, post, msg)
`endif
`endif

[design/bsa_pkg.sv]
// shared types and constants of the bitmap slot allocator
`timescale 1ns / 1ps
package bsa_pkg;

  // width of the slot index fields on the channels
  localparam int SLOT_W = 13;
  // shift of the fixed-point reciprocal used to split a slot index
  localparam int DIV_SH = 20;
  // highest-allocated mark after reset
  localparam int HIGH_RESET = 2;

  // request opcodes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bsa_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic div_step;
    logic rd_low;
    logic rd_free;
    logic alloc_wr;
    logic skip_word;
    logic free_wr;
    logic load_out;
    logic res_ok;
    logic res_grant;
  } bsa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic req_free;
    logic slot_ok;
    logic low_end;
    logic low_last;
    logic word_full;
    logic out_free;
  } bsa_sts_t;

endpackage

[design/bsa_if.sv]
// request and result channel interfaces
`timescale 1ns / 1ps
interface bsa_req_if;
  import bsa_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [SLOT_W-1:0] slot_index;
  modport source (output valid, output command, output slot_index, input ready);
  modport sink (input valid, input command, input slot_index, output ready);
endinterface

interface bsa_rsp_if;
  import bsa_pkg::*;
  logic              valid;
  logic              ready;
  logic              success;
  logic [SLOT_W-1:0] granted_index;
  logic [SLOT_W-1:0] highest_index;
  modport source (output valid, output success, output granted_index,
                  output highest_index, input ready);
  modport sink (input valid, input success, input granted_index,
                input highest_index, output ready);
endinterface

[design/bitmap_slot_allocator_top.sv]
// top level of the bitmap slot allocator
`timescale 1ns / 1ps
// channel   dir  handshake      word contents
// in_ch     in   valid/ready    command, slot_index
// out_ch    out  valid/ready    success, granted_index, highest_index
//
// allocate: read and set a bit in the hinted word when it is the first non-full one,
//   with a read and a skip for each full word stepped over by the hint; result only when full
// free: reciprocal split of the index, read, clear, result
// the occupancy memory (one read and one write port) and the one-word search set these steps
// reset is synchronous; a fill count makes never-written words read as free
// a new word is taken while the previous result waits in the output register
module bitmap_slot_allocator_top #(
  parameter int NUM_SLOTS = 8192,
  parameter int WORD_BITS = 32
) (
  input logic     clk,
  input logic     rst_n,
  bsa_req_if.sink   in_ch,
  bsa_rsp_if.source out_ch
);
  import bsa_pkg::*;

  bsa_cmd_t cmd;
  bsa_sts_t sts;

  // sequencer
  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  bsa_dpath #(
    .NUM_SLOTS (NUM_SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_ch.command),
    .in_slot_index     (in_ch.slot_index),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_success       (out_ch.success),
    .out_granted_index (out_ch.granted_index),
    .out_highest_index (out_ch.highest_index)
  );

endmodule

[design/bsa_ctrl.sv]
// sequencing state machine of the slot allocator
`timescale 1ns / 1ps
module bsa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bsa_pkg::bsa_sts_t sts,
  output bsa_pkg::bsa_cmd_t cmd
);
  import bsa_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_FRD  = 7'b0000100,
    ST_FWR  = 7'b0001000,
    ST_ARD  = 7'b0010000,
    ST_AWR  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ok_r, ok_nxt;
  logic   grant_r, grant_nxt;

  // state and outcome registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ok_r    <= 1'b0;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
      grant_r <= grant_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    grant_nxt = grant_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          ok_nxt      = 1'b0;
          grant_nxt   = 1'b0;
          if (sts.req_free) begin
            state_nxt = ST_DIV;
          end else if (sts.low_end) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ARD;
          end
        end
      end
      ST_DIV: begin
        if (sts.slot_ok) begin
          cmd.div_step = 1'b1;
          state_nxt    = ST_FRD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FRD: begin
        cmd.rd_free = 1'b1;
        state_nxt   = ST_FWR;
      end
      ST_FWR: begin
        cmd.free_wr = 1'b1;
        ok_nxt      = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_ARD: begin
        cmd.rd_low = 1'b1;
        state_nxt  = ST_AWR;
      end
      ST_AWR: begin
        if (sts.word_full) begin
          cmd.skip_word = 1'b1;
          state_nxt     = sts.low_last ? ST_FIN : ST_ARD;
        end else begin
          cmd.alloc_wr = 1'b1;
          ok_nxt       = 1'b1;
          grant_nxt    = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.res_ok    = ok_r;
          cmd.res_grant = grant_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/bsa_dpath.sv]
// occupancy memory, search, index split and result register
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_top_macros.svh"
module bsa_dpath #(
  parameter int NUM_SLOTS = 8192,
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bsa_pkg::bsa_cmd_t          cmd,
  output bsa_pkg::bsa_sts_t          sts,
  input  logic                       in_command,
  input  logic [bsa_pkg::SLOT_W-1:0] in_slot_index,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_success,
  output logic [bsa_pkg::SLOT_W-1:0] out_granted_index,
  output logic [bsa_pkg::SLOT_W-1:0] out_highest_index
);
  import bsa_pkg::*;

  localparam int NUM_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LOW_W     = $clog2(NUM_WORDS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int LAST_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_VALID =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
  localparam int RECIP     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W   = DIV_SH - BIT_W + 1;
  localparam int PROD_W    = SLOT_W + RECIP_W;
  localparam int QF_W      = PROD_W - DIV_SH;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  logic [SLOT_W-1:0]    slot_r;
  logic [WA_W-1:0]      q_r;
  logic [BIT_W-1:0]     rem_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 fresh_r;
  logic [LOW_W-1:0]     low_r;
  logic [LOW_W-1:0]     touched_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     highest_r;
  logic                 out_valid_r;
  logic                 out_success_r;
  logic [SLOT_W-1:0]    out_granted_r;
  logic [SLOT_W-1:0]    out_highest_r;

  logic [PROD_W-1:0]    prod;
  logic [QF_W-1:0]      q_full;
  logic [SLOT_W-1:0]    q_base;
  logic [SLOT_W-1:0]    rem_full;
  logic [WA_W-1:0]      raddr;
  logic [WA_W-1:0]      waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;
  logic [WORD_BITS-1:0] word_cur;
  logic [WORD_BITS-1:0] eff;
  logic [WORD_BITS-1:0] inv;
  logic [WORD_BITS-1:0] first_zero;
  logic [BIT_W-1:0]     enc;
  logic [IDX_W-1:0]     base;
  logic [IDX_W-1:0]     highest_nxt;
  logic [LOW_W-1:0]     waddr_next;
  logic                 word_full;

  // slot index split: reciprocal multiply, then remainder next cycle
  assign prod     = PROD_W'(slot_r) * PROD_W'(RECIP);
  assign q_full   = prod[PROD_W-1:DIV_SH];
  assign q_base   = SLOT_W'(q_r * WORD_BITS);
  assign rem_full = slot_r - q_base;

  // current word, with never-written words reading as free
  assign word_cur = fresh_r ? '0 : rdata_r;
  assign eff      = word_cur | (sts.low_last ? ~LAST_VALID : '0);
  assign word_full = &eff;

  // lowest clear bit as one-hot, then its position
  assign inv        = ~eff;
  assign first_zero = inv & (~inv + WORD_BITS'(1));
  always_comb begin
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (first_zero[i]) begin
        enc = enc | BIT_W'(i);
      end
    end
  end

  assign base = IDX_W'(low_r * WORD_BITS);

  // memory port selection
  assign raddr = cmd.rd_low ? low_r[WA_W-1:0] : q_r;
  assign we    = cmd.alloc_wr || cmd.free_wr;
  assign waddr = cmd.alloc_wr ? low_r[WA_W-1:0] : q_r;
  assign wdata = cmd.alloc_wr ? (word_cur | first_zero)
                              : (word_cur & ~(WORD_BITS'(1) << rem_r));
  assign waddr_next = LOW_W'(waddr) + LOW_W'(1);

  // occupancy memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_low || cmd.rd_free) begin
      rdata_r <= mem[raddr];
      fresh_r <= (LOW_W'(raddr) >= touched_r);
    end
  end

  // request capture and index split registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r <= in_slot_index;
    end
    if (cmd.div_step) begin
      q_r <= WA_W'(q_full);
    end
    if (cmd.rd_free) begin
      rem_r <= BIT_W'(rem_full);
    end
    if (cmd.alloc_wr) begin
      idx_r <= base + IDX_W'(enc);
    end
  end

  assign highest_nxt = (cmd.res_grant && (idx_r > highest_r)) ? idx_r : highest_r;

  // search hint, fill count and highest mark
  // the fill count grows only with allocations, which stay contiguous from word 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r     <= '0;
      touched_r <= '0;
      highest_r <= IDX_W'(HIGH_RESET);
    end else begin
      if (cmd.skip_word) begin
        low_r <= low_r + LOW_W'(1);
      end else if (cmd.free_wr && (LOW_W'(q_r) < low_r)) begin
        low_r <= LOW_W'(q_r);
      end
      if (cmd.alloc_wr && (waddr_next > touched_r)) begin
        touched_r <= waddr_next;
      end
      if (cmd.load_out) begin
        highest_r <= highest_nxt;
      end
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_success_r <= cmd.res_ok;
      out_granted_r <= cmd.res_grant ? SLOT_W'(idx_r) : '0;
      out_highest_r <= SLOT_W'(highest_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_success       = out_success_r;
  assign out_granted_index = out_granted_r;
  assign out_highest_index = out_highest_r;

  // status to the controller
  assign sts.req_free  = (in_command == CMD_FREE);
  assign sts.slot_ok   = (32'(slot_r) < NUM_SLOTS);
  assign sts.low_end   = (low_r == LOW_W'(NUM_WORDS));
  assign sts.low_last  = (low_r == LOW_W'(NUM_WORDS - 1));
  assign sts.word_full = word_full;
  assign sts.out_free  = !out_valid_r || out_ready;

  // checks
  `BSA_ASSERT(a_low_range, clk, rst_n, low_r <= LOW_W'(NUM_WORDS), "search hint past end")
  `BSA_ASSERT(a_alloc_free_bit, clk, rst_n, cmd.alloc_wr |-> !word_full, "alloc into full word")
  `BSA_ASSERT(a_load_free, clk, rst_n, cmd.load_out |-> sts.out_free, "result overwritten")
  `BSA_ASSERT_NXT(a_grant_range, clk, rst_n, cmd.alloc_wr, 32'(idx_r) < NUM_SLOTS, "bad index")
  `BSA_ASSERT_NXT(a_high_mono, clk, rst_n, 1'b1, highest_r >= $past(highest_r), "mark fell")

endmodule
